[rtl/tinc_pkg.sv]
package tinc_pkg;

  // Fixed widths of the item fields
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned TOTAL_W  = 8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } walk_state_e;

  typedef struct packed {
    logic [TOTAL_W-1:0] node_total;
    logic               created;
    logic               pool_full;
  } result_t;

endpackage

[rtl/tinc_table.sv]
// Child table: one write port, one read port, registered read data.
module tinc_table #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] wa_i,
  input  logic [DATA_W-1:0] wd_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] ra_i,
  output logic [DATA_W-1:0] rd_o
);

  localparam int unsigned Depth = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem [Depth];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

[rtl/tinc_walk.sv]
// Trie walker: clears the table, then per symbol reads the child entry,
// follows it, allocates and writes back a node, or flags pool_full.
module tinc_walk #(
  parameter int unsigned NODE_W = 8,
  parameter int unsigned SYM_W  = 8,
  parameter int unsigned NODE_POOL = 256,
  parameter int unsigned ALPHABET  = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tinc_pkg::SYMBOL_W-1:0] symbol_i,
  input  logic                        word_start_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output tinc_pkg::result_t           res_o,
  output logic                        mem_re_o,
  output logic [NODE_W+SYM_W-1:0]     mem_ra_o,
  output logic                        mem_we_o,
  output logic [NODE_W+SYM_W-1:0]     mem_wa_o,
  output logic [NODE_W:0]             mem_wd_o,
  input  logic [NODE_W:0]             mem_rd_i
);

  localparam int unsigned AddrW = NODE_W + SYM_W;
  localparam logic [NODE_W-1:0] CntMax = NODE_W'(NODE_POOL - 1);
  localparam logic [tinc_pkg::SYMBOL_W:0] SymLimit = (tinc_pkg::SYMBOL_W + 1)'(ALPHABET);

  tinc_pkg::walk_state_e state_q, state_d;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] cnt_q, cnt_d;
  logic              lost_q, lost_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic              ok_q, ok_d;

  logic [NODE_W-1:0]   node_eff;
  logic [SYM_W-1:0]    sym_idx;
  logic                sym_ok;
  logic [NODE_W-1:0]   cnt_inc;
  logic                created;
  logic                full;
  logic [NODE_W+tinc_pkg::TOTAL_W-1:0] tot_ext;

  assign node_eff = word_start_i ? '0 : cur_q;
  assign sym_idx  = symbol_i[SYM_W-1:0];
  assign sym_ok   = {1'b0, symbol_i} < SymLimit;
  assign cnt_inc  = cnt_q + NODE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tinc_pkg::ST_CLEAR;
      cur_q   <= '0;
      cnt_q   <= '0;
      lost_q  <= 1'b0;
      clr_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      lost_q  <= lost_d;
      clr_q   <= clr_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    sym_q  <= sym_d;
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    lost_d  = lost_q;
    clr_d   = clr_q;
    node_d  = node_q;
    sym_d   = sym_q;
    ok_d    = ok_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    created  = 1'b0;
    full     = 1'b0;
    mem_re_o = 1'b0;
    mem_ra_o = {node_eff, sym_idx};
    mem_we_o = 1'b0;
    mem_wa_o = clr_q;
    mem_wd_o = '0;
    unique case (state_q)
      tinc_pkg::ST_CLEAR: begin
        mem_we_o = 1'b1;
        clr_d    = clr_q + AddrW'(1);
        if (&clr_q) begin
          state_d = tinc_pkg::ST_IDLE;
        end
      end
      tinc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mem_re_o = 1'b1;
          cur_d    = node_eff;
          node_d   = node_eff;
          lost_d   = word_start_i ? 1'b0 : lost_q;
          sym_d    = sym_idx;
          ok_d     = sym_ok;
          state_d  = tinc_pkg::ST_LOOK;
        end
      end
      tinc_pkg::ST_LOOK: begin
        res_valid_o = 1'b1;
        if (ok_q) begin
          if (lost_q) begin
            full = 1'b1;
          end else if (!mem_rd_i[NODE_W] && cnt_q == CntMax) begin
            full = 1'b1;
          end else if (!mem_rd_i[NODE_W]) begin
            created = 1'b1;
          end
        end
        if (res_ready_i) begin
          state_d = tinc_pkg::ST_IDLE;
          if (ok_q && !lost_q) begin
            if (mem_rd_i[NODE_W]) begin
              cur_d = mem_rd_i[NODE_W-1:0];
            end else if (created) begin
              cnt_d    = cnt_inc;
              cur_d    = cnt_inc;
              mem_we_o = 1'b1;
              mem_wa_o = {node_q, sym_q};
              mem_wd_o = {1'b1, cnt_inc};
            end else begin
              lost_d = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = tinc_pkg::ST_CLEAR;
      end
    endcase
  end

  // Count after this item, wrapped to the output width
  assign tot_ext = {{tinc_pkg::TOTAL_W{1'b0}}, (created ? cnt_inc : cnt_q)};

  always_comb begin
    res_o.node_total = tot_ext[tinc_pkg::TOTAL_W-1:0];
    res_o.created    = created;
    res_o.pool_full  = full;
  end

endmodule

[rtl/trie_insert_node_count_core.sv]
// Path: an input transfer starts the child table read; in the lookup state the result
//   is taken into the output register behind out_valid_o; a stalled output holds the walk.
// Pacing: a new symbol is taken only after the previous lookup has passed its result on,
//   as the child table's registered read picks the next current node before the next symbol may be looked up.
// Reset (rst_ni low, asynchronous): walk returns to the root, node count and lost
//   flag clear, then a clearing pass writes all 2**(clog2(NODE_POOL)+clog2(ALPHABET))
//   table entries (65536 at the defaults); in_ready_o stays low meanwhile.
module trie_insert_node_count_core #(
  parameter int unsigned NODE_POOL = 256,
  parameter int unsigned ALPHABET  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tinc_pkg::SYMBOL_W-1:0] symbol_i,
  input  logic                          word_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tinc_pkg::TOTAL_W-1:0]  node_total_o,
  output logic                          created_o,
  output logic                          pool_full_o
);

  // Node numbers and symbol indexes; the table address is {node, symbol}
  localparam int unsigned NodeW = $clog2(NODE_POOL);
  localparam int unsigned SymW  = $clog2(ALPHABET);
  localparam int unsigned AddrW = NodeW + SymW;

  logic              mem_re;
  logic [AddrW-1:0]  mem_ra;
  logic              mem_we;
  logic [AddrW-1:0]  mem_wa;
  logic [NodeW:0]    mem_wd;
  logic [NodeW:0]    mem_rd;

  logic              res_valid;
  logic              res_ready;
  tinc_pkg::result_t res;

  // Output register, parts the walker from the downstream stall
  logic              out_valid_q, out_valid_d;
  tinc_pkg::result_t res_q;

  // Entry: valid bit on top, child node number below
  tinc_table #(
    .ADDR_W (AddrW),
    .DATA_W (NodeW + 1)
  ) u_table (
    .clk_i (clk_i),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .re_i  (mem_re),
    .ra_i  (mem_ra),
    .rd_o  (mem_rd)
  );

  tinc_walk #(
    .NODE_W    (NodeW),
    .SYM_W     (SymW),
    .NODE_POOL (NODE_POOL),
    .ALPHABET  (ALPHABET)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .symbol_i     (symbol_i),
    .word_start_i (word_start_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_re_o     (mem_re),
    .mem_ra_o     (mem_ra),
    .mem_we_o     (mem_we),
    .mem_wa_o     (mem_wa),
    .mem_wd_o     (mem_wd),
    .mem_rd_i     (mem_rd)
  );

  // The slot frees up in the same cycle as the downstream transfer
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_total_o = res_q.node_total;
  assign created_o    = res_q.created;
  assign pool_full_o  = res_q.pool_full;

  // A symbol either creates a node or reports exhaustion, never both
  a_created_excl_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !(res.created && res.pool_full))
    else $error("created and pool_full both set");

  // One symbol in flight: no transfer straight after an input transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && res_valid)
    else $error("input taken while a lookup is pending");

  // The table is never written while the walker can take a symbol
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mem_we)
    else $error("table write while idle");

endmodule

[tb/tb_trie_insert_node_count_core.sv]
`timescale 1ns / 1ps

// Trie insertion counter: words go in one symbol per transfer, and every
// transfer returns the number of trie nodes created so far. The bench keeps
// its own trie, predicts each result when the input transfer is accepted and
// compares the returned transfers in order, field by field.
module tb_trie_insert_node_count_core;

  localparam int unsigned NodePool = 256;
  localparam int unsigned Alphabet = 256;
  localparam int unsigned TableSize = NodePool * Alphabet;
  localparam int unsigned VocabSize = 32;
  localparam int unsigned MaxWordLen = 8;
  localparam int unsigned TargetSymbols = 450;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [tinc_pkg::SYMBOL_W-1:0] symbol;
  logic                          word_start;
  logic                          out_valid;
  logic                          out_ready;
  logic [tinc_pkg::TOTAL_W-1:0]  node_total;
  logic                          created;
  logic                          pool_full;

  // Shadow trie: valid bit and child number per (node, symbol) slot
  bit          trie_valid [TableSize];
  int unsigned trie_child [TableSize];
  int unsigned walk_node;
  int unsigned node_count;
  bit          walk_lost;

  tinc_pkg::result_t predicted_counts [$];
  int                mismatches;
  int                symbols_sent;
  int                results_seen;

  // No-idle stretches: when set, neither side inserts gaps or stalls
  bit burst;

  // Words already sent, replayed to walk and branch off existing prefixes
  logic [tinc_pkg::SYMBOL_W-1:0] vocab_sym [VocabSize][MaxWordLen];
  int                            vocab_len [VocabSize];
  int                            vocab_n;

  trie_insert_node_count_core #(
    .NODE_POOL(NodePool),
    .ALPHABET (Alphabet)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .symbol_i    (symbol),
    .word_start_i(word_start),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .node_total_o(node_total),
    .created_o   (created),
    .pool_full_o (pool_full)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Walk one symbol through the shadow trie and return the result it owes.
  function automatic tinc_pkg::result_t trie_insert(
    input logic [tinc_pkg::SYMBOL_W-1:0] sym,
    input logic                          start
  );
    int unsigned       slot;
    tinc_pkg::result_t res;
    res = '0;
    if (start) begin
      walk_node = 0;
      walk_lost = 1'b0;
    end
    // Out-of-alphabet symbols are ignored; unreachable while Alphabet is 256
    if (int'(sym) < Alphabet) begin
      if (walk_lost) begin
        // word already fell off the trie when the pool ran out
        res.pool_full = 1'b1;
      end else begin
        slot = walk_node * Alphabet + int'(sym);
        if (trie_valid[slot]) begin
          walk_node = trie_child[slot];
        end else if (node_count < NodePool - 1) begin
          node_count++;
          trie_valid[slot] = 1'b1;
          trie_child[slot] = node_count;
          walk_node = node_count;
          res.created = 1'b1;
        end else begin
          // pool exhausted: count held, rest of the word is lost
          res.pool_full = 1'b1;
          walk_lost = 1'b1;
        end
      end
    end
    res.node_total = tinc_pkg::TOTAL_W'(node_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Prediction on every accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predicted_counts = {predicted_counts, trie_insert(symbol, word_start)};
    end
  end

  // Check every accepted output transfer against the oldest prediction
  always @(posedge clk) begin
    tinc_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_counts.size() == 0) begin
        report_mismatch("unexpected transfer, node_total", int'(node_total), 0);
      end else begin
        want = predicted_counts.pop_front();
        if (node_total !== want.node_total) begin
          report_mismatch("node_total", int'(node_total), int'(want.node_total));
        end
        if (created !== want.created) begin
          report_mismatch("created", int'(created), int'(want.created));
        end
        if (pool_full !== want.pool_full) begin
          report_mismatch("pool_full", int'(pool_full), int'(want.pool_full));
        end
      end
      results_seen++;
    end
  end

  // Result side: random stall before each transfer, none while burst is set
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One input transfer. Valid is left high on return so that a back-to-back
  // item only updates the payload; it is dropped only before a gap.
  task automatic send_symbol(input logic [tinc_pkg::SYMBOL_W-1:0] sym, input logic start);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    symbol     <= sym;
    word_start <= start;
    do @(posedge clk); while (!in_ready);
    symbols_sent++;
  endtask

  // One word: either fresh random content or a replay of a known word, cut
  // short or extended so it branches off an existing prefix. Now and then the
  // start flag is dropped, so the word runs on from the previous one.
  task automatic send_word(input int reuse_pct);
    logic [tinc_pkg::SYMBOL_W-1:0] w [MaxWordLen];
    int                            len;
    int                            keep;
    int                            k;
    int                            i;
    if (vocab_n > 0 && $urandom_range(0, 99) < reuse_pct) begin
      k    = $urandom_range(0, vocab_n - 1);
      keep = $urandom_range(1, vocab_len[k]);
      len  = ($urandom_range(0, 2) == 0) ? $urandom_range(keep, MaxWordLen) : keep;
      for (i = 0; i < MaxWordLen; i++) begin
        w[i] = (i < keep) ? vocab_sym[k][i] : tinc_pkg::SYMBOL_W'($urandom);
      end
    end else begin
      len = $urandom_range(1, 6);
      for (i = 0; i < MaxWordLen; i++) begin
        w[i] = tinc_pkg::SYMBOL_W'($urandom);
      end
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = !burst;
    end
    for (i = 0; i < len; i++) begin
      send_symbol(w[i], (i == 0) && ($urandom_range(0, 19) != 0));
    end
    if (vocab_n < VocabSize) begin
      k = vocab_n;
      vocab_n++;
    end else begin
      k = $urandom_range(0, VocabSize - 1);
    end
    vocab_len[k] = len;
    for (i = 0; i < MaxWordLen; i++) begin
      vocab_sym[k][i] = w[i];
    end
  endtask

  // Hand-picked words: first symbol with no start flag, symbol extremes,
  // and repeats of known words.
  task automatic test_directed_prefixes();
    send_symbol(8'h00, 1'b0);  // walk begins at the root after reset
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h00, 1'b1);  // known prefix, nothing created
    send_symbol(8'hff, 1'b0);
    send_symbol(8'hff, 1'b0);  // branch below a known prefix
    send_symbol(8'hff, 1'b1);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h55, 1'b1);
    send_symbol(8'haa, 1'b0);
    send_symbol(8'h00, 1'b1);  // full repeat of an earlier word
    send_symbol(8'hff, 1'b0);
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h80, 1'b1);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'h7f, 1'b0);  // third symbol of the same word
    send_symbol(8'hfe, 1'b1);
    send_symbol(8'hfe, 1'b1);  // single-symbol word seen twice
  endtask

  // Mostly replayed words so that walks go deep through shared prefixes
  task automatic test_shared_prefixes();
    while (symbols_sent < 170) begin
      send_word(65);
    end
  endtask

  // Fresh words until the pool runs out, then a mix of known words, which
  // must still walk, and new ones, which must report the pool as full.
  task automatic test_pool_exhaustion();
    while (node_count < NodePool - 1) begin
      send_word(10);
    end
    while (symbols_sent < TargetSymbols) begin
      send_word(50);
    end
  endtask

  initial begin
    in_valid   <= 1'b0;
    symbol     <= '0;
    word_start <= 1'b0;
    rst_n      <= 1'b0;
    burst = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // in_ready stays low through the table clearing pass after reset
    test_directed_prefixes();
    test_shared_prefixes();
    test_pool_exhaustion();
    in_valid <= 1'b0;

    while (predicted_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0 && predicted_counts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Time limit long enough for the clearing pass and the whole stimulus
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
rtl/tinc_pkg.sv
rtl/tinc_table.sv
rtl/tinc_walk.sv
rtl/trie_insert_node_count_core.sv
tb/tb_trie_insert_node_count_core.sv
